>>> rtl/xcpd_pkg.sv
// ----------------------------------------------------------------------------
// XOR-checked packet deframer package
// Shared constants, event codes and the result record of the deframer.
// ----------------------------------------------------------------------------
package xcpd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned EVENT_W = 3;

    // Header is length, type, source, destination and check byte.
    localparam logic [POS_W-1:0]  HDR_LEN    = POS_W'(5);
    localparam logic [BYTE_W-1:0] HDR_INVERT = 8'hFF;

    // Header byte positions inside a frame.
    localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SRC   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DEST  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(4);

    typedef enum logic [EVENT_W-1:0] {
        EV_HEADER     = 3'd0,
        EV_HDR_FAIL   = 3'd1,
        EV_PAYLOAD    = 3'd2,
        EV_FRAME_GOOD = 3'd3,
        EV_FRAME_BAD  = 3'd4
    } event_t;

    typedef struct packed {
        event_t              event_res;
        logic [BYTE_W-1:0]   payload_byte;
        logic [POS_W-1:0]    payload_index;
        logic [BYTE_W-1:0]   frame_length;
        logic [BYTE_W-1:0]   frame_type;
        logic [BYTE_W-1:0]   frame_source;
        logic [BYTE_W-1:0]   frame_dest;
        logic                receiving;
    } result_t;

endpackage

>>> rtl/xcpd_in_stage.sv
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers one received byte and holds it until the core takes it.
// ----------------------------------------------------------------------------
module xcpd_in_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [xcpd_pkg::BYTE_W-1:0]  s_rx_byte,
    input  logic                         take,
    output logic                         byte_valid,
    output logic [xcpd_pkg::BYTE_W-1:0]  byte_data
);
    import xcpd_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    // The stage refills in the same cycle that the core consumes it.
    assign s_ready    = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule

>>> rtl/xcpd_core.sv
// ----------------------------------------------------------------------------
// Deframer core
// Frame state, header check and payload XOR; one byte per take.
// ----------------------------------------------------------------------------
module xcpd_core #(
    parameter int unsigned MAX_DATA = 47
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         take,
    input  logic [xcpd_pkg::BYTE_W-1:0]  byte_data,
    output xcpd_pkg::result_t            result
);
    import xcpd_pkg::*;

    localparam logic [POS_W-1:0] LastPos = POS_W'(MAX_DATA + 5);

    logic              bypass_reg;
    logic              in_frame_reg,  in_frame_next;
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [BYTE_W-1:0] xor_reg,       xor_next;
    logic [BYTE_W-1:0] length_reg,    length_next;
    logic [BYTE_W-1:0] type_reg,      type_next;
    logic [BYTE_W-1:0] source_reg,    source_next;
    logic [BYTE_W-1:0] dest_reg,      dest_next;

    logic [BYTE_W-1:0] payload_xor;
    logic              last_byte;
    logic              frame_good;

    assign payload_xor = xor_reg ^ byte_data;
    assign last_byte   = ({3'b000, pos_reg} >= ({1'b0, length_reg} + 9'(HDR_LEN)))
                         || (pos_reg >= LastPos);
    assign frame_good  = (bypass_reg && (type_reg == '0)) || (payload_xor == '0);

    always_comb begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        xor_next      = xor_reg;
        length_next   = length_reg;
        type_next     = type_reg;
        source_next   = source_reg;
        dest_next     = dest_reg;

        result.event_res     = EV_HEADER;
        result.payload_byte  = '0;
        result.payload_index = '0;

        if (!in_frame_reg) begin
            // Any byte while idle opens a frame as its length byte.
            in_frame_next = 1'b1;
            pos_next      = POS_TYPE;
            length_next   = byte_data;
            type_next     = '0;
            source_next   = '0;
            dest_next     = '0;
            xor_next      = byte_data;
        end else begin
            case (pos_reg)
                POS_TYPE: begin
                    type_next = byte_data;
                    xor_next  = payload_xor;
                    pos_next  = POS_SRC;
                end
                POS_SRC: begin
                    source_next = byte_data;
                    xor_next    = payload_xor;
                    pos_next    = POS_DEST;
                end
                POS_DEST: begin
                    dest_next = byte_data;
                    xor_next  = payload_xor;
                    pos_next  = POS_CHECK;
                end
                POS_CHECK: begin
                    if ((xor_reg ^ HDR_INVERT) != byte_data) begin
                        in_frame_next    = 1'b0;
                        result.event_res = EV_HDR_FAIL;
                    end else begin
                        pos_next = HDR_LEN;
                        xor_next = '0;
                    end
                end
                default: begin
                    xor_next             = payload_xor;
                    result.payload_byte  = byte_data;
                    result.payload_index = pos_reg - HDR_LEN;
                    if (last_byte) begin
                        in_frame_next    = 1'b0;
                        result.event_res = frame_good ? EV_FRAME_GOOD : EV_FRAME_BAD;
                    end else begin
                        pos_next         = pos_reg + POS_W'(1);
                        result.event_res = EV_PAYLOAD;
                    end
                end
            endcase
        end

        result.frame_length = length_next;
        result.frame_type   = type_next;
        result.frame_source = source_next;
        result.frame_dest   = dest_next;
        result.receiving    = in_frame_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg   <= 1'b1;
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            xor_reg      <= '0;
            length_reg   <= '0;
            type_reg     <= '0;
            source_reg   <= '0;
            dest_reg     <= '0;
        end else begin
            if (cfg_we) begin
                bypass_reg <= cfg_wdata;
            end
            if (take) begin
                in_frame_reg <= in_frame_next;
                pos_reg      <= pos_next;
                xor_reg      <= xor_next;
                length_reg   <= length_next;
                type_reg     <= type_next;
                source_reg   <= source_next;
                dest_reg     <= dest_next;
            end
        end
    end

endmodule

>>> rtl/xcpd_out_stage.sv
// ----------------------------------------------------------------------------
// Deframer output stage
// Result register that holds one item until the sink takes it.
// ----------------------------------------------------------------------------
module xcpd_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  xcpd_pkg::result_t  result,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output xcpd_pkg::result_t  m_result
);
    import xcpd_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

>>> rtl/xor_checked_packet_deframer.sv
// ----------------------------------------------------------------------------
// XOR-checked packet deframer
// Deframes radio packets byte by byte with header and payload XOR checks.
// ----------------------------------------------------------------------------
// Each received item is one byte. A frame opens with five header bytes
// (length, type, source, destination, check); the check byte must equal the
// XOR of the first four XOR 0xFF, or the frame is dropped and the next byte
// starts a new one. Then length+1 payload bytes follow, the last being an XOR
// byte, capped at MAX_DATA+1 bytes. Every byte yields exactly one result item
// carrying the event code, the payload byte and index, the held header fields
// and the receiving flag. The frame is good when the type is zero with the
// bypass register set, or when the payload XOR including its last byte is
// zero. The block takes one item per clock cycle while the result register
// is free or being emptied, set by the single register stage of frame state
// in the core. A byte's result is loaded into the result register when the
// core takes the byte from the input stage. While a result waits, the input
// stage takes one more item, then holds s_ready low until the result goes.
// The bypass register resets to 1 and should be written only while idle.
// ----------------------------------------------------------------------------
module xor_checked_packet_deframer #(
    parameter int unsigned MAX_DATA = 47
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_payload_byte,
    output logic [5:0]  m_payload_index,
    output logic [7:0]  m_frame_length,
    output logic [7:0]  m_frame_type,
    output logic [7:0]  m_frame_source,
    output logic [7:0]  m_frame_dest,
    output logic        m_receiving
);
    import xcpd_pkg::*;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              out_free;
    logic              take;
    result_t           core_result;
    result_t           m_result;

    // A byte moves through the core whenever one is held and the result
    // register is free or being emptied in the same cycle.
    assign take = byte_valid && out_free;

    xcpd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    xcpd_core #(
        .MAX_DATA (MAX_DATA)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .byte_data (byte_data),
        .result    (core_result)
    );

    xcpd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .result   (core_result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_event_res     = m_result.event_res;
    assign m_payload_byte  = m_result.payload_byte;
    assign m_payload_index = m_result.payload_index;
    assign m_frame_length  = m_result.frame_length;
    assign m_frame_type    = m_result.frame_type;
    assign m_frame_source  = m_result.frame_source;
    assign m_frame_dest    = m_result.frame_dest;
    assign m_receiving     = m_result.receiving;

endmodule

>>> dv/xcpd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer result checker
// Watches both channels of the deframer, predicts every result item from the
// accepted bytes and compares the two, field by field, in order.
// ----------------------------------------------------------------------------
module xcpd_frame_checker #(
    parameter int unsigned MAX_DATA = 47
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_event_res,
    input  logic [7:0]  m_payload_byte,
    input  logic [5:0]  m_payload_index,
    input  logic [7:0]  m_frame_length,
    input  logic [7:0]  m_frame_type,
    input  logic [7:0]  m_frame_source,
    input  logic [7:0]  m_frame_dest,
    input  logic        m_receiving,
    output int          mismatch_count,
    output int          results_waiting,
    output int          frames_good,
    output int          frames_bad,
    output int          header_fails
);
    import xcpd_pkg::*;

    // Shadow copy of the deframer state and its bypass register.
    logic              in_frame;
    logic [POS_W-1:0]  byte_pos;
    logic [BYTE_W-1:0] run_xor;
    logic [BYTE_W-1:0] held_len;
    logic [BYTE_W-1:0] held_type;
    logic [BYTE_W-1:0] held_src;
    logic [BYTE_W-1:0] held_dst;
    logic              bypass;

    result_t expected_results[$];

    function automatic result_t deframe_byte(input logic [BYTE_W-1:0] c);
        result_t     r;
        int unsigned pos;
        logic        good;
        r = '0;
        r.event_res = EV_HEADER;
        if (!in_frame) begin
            in_frame  = 1'b1;
            byte_pos  = POS_TYPE;
            held_len  = c;
            held_type = '0;
            held_src  = '0;
            held_dst  = '0;
            run_xor   = c;
        end else if (byte_pos == POS_TYPE) begin
            held_type = c;
            run_xor  ^= c;
            byte_pos  = POS_SRC;
        end else if (byte_pos == POS_SRC) begin
            held_src  = c;
            run_xor  ^= c;
            byte_pos  = POS_DEST;
        end else if (byte_pos == POS_DEST) begin
            held_dst  = c;
            run_xor  ^= c;
            byte_pos  = POS_CHECK;
        end else if (byte_pos == POS_CHECK) begin
            if ((run_xor ^ HDR_INVERT) != c) begin
                in_frame    = 1'b0;
                r.event_res = EV_HDR_FAIL;
            end else begin
                byte_pos = HDR_LEN;
                run_xor  = '0;
            end
        end else begin
            pos             = 32'(byte_pos);
            run_xor        ^= c;
            r.payload_byte  = c;
            r.payload_index = POS_W'(pos - int'(HDR_LEN));
            if (pos >= int'(held_len) + int'(HDR_LEN) ||
                pos >= MAX_DATA + int'(HDR_LEN)) begin
                good        = (bypass && held_type == '0) || run_xor == '0;
                in_frame    = 1'b0;
                r.event_res = good ? EV_FRAME_GOOD : EV_FRAME_BAD;
            end else begin
                byte_pos = POS_W'(pos + 1);
                r.event_res = EV_PAYLOAD;
            end
        end
        r.frame_length = held_len;
        r.frame_type   = held_type;
        r.frame_source = held_src;
        r.frame_dest   = held_dst;
        r.receiving    = in_frame;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            in_frame  = 1'b0;
            byte_pos  = '0;
            run_xor   = '0;
            held_len  = '0;
            held_type = '0;
            held_src  = '0;
            held_dst  = '0;
            bypass    = 1'b1;
            expected_results.delete();
            mismatch_count = 0;
            frames_good    = 0;
            frames_bad     = 0;
            header_fails   = 0;
        end else begin
            if (cfg_we)
                bypass = cfg_wdata;
            if (s_valid && s_ready)
                expected_results.push_back(deframe_byte(s_rx_byte));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_res",     32'(want.event_res),
                                32'(m_event_res));
                    check_field("payload_byte",  32'(want.payload_byte),
                                32'(m_payload_byte));
                    check_field("payload_index", 32'(want.payload_index),
                                32'(m_payload_index));
                    check_field("frame_length",  32'(want.frame_length),
                                32'(m_frame_length));
                    check_field("frame_type",    32'(want.frame_type),
                                32'(m_frame_type));
                    check_field("frame_source",  32'(want.frame_source),
                                32'(m_frame_source));
                    check_field("frame_dest",    32'(want.frame_dest),
                                32'(m_frame_dest));
                    check_field("receiving",     32'(want.receiving),
                                32'(m_receiving));
                    case (want.event_res)
                        EV_FRAME_GOOD: frames_good++;
                        EV_FRAME_BAD:  frames_bad++;
                        EV_HDR_FAIL:   header_fails++;
                        default: ;
                    endcase
                end
            end
        end
        results_waiting <= expected_results.size();
    end

endmodule

>>> dv/tb_xor_checked_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR-checked packet deframer testbench
// Streams whole frames, broken headers and loose bytes into the deframer
// under several handshake pressure patterns, toggling the type-zero bypass
// between phases; a side checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_xor_checked_packet_deframer;

    localparam int unsigned MAX_DATA    = 47;
    // Random bytes sent in each of the four handshake phases.
    localparam int          PHASE_BYTES = 175;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_event_res;
    logic [7:0] m_payload_byte;
    logic [5:0] m_payload_index;
    logic [7:0] m_frame_length;
    logic [7:0] m_frame_type;
    logic [7:0] m_frame_source;
    logic [7:0] m_frame_dest;
    logic       m_receiving;

    int mismatch_count;
    int results_waiting;
    int frames_good;
    int frames_bad;
    int header_fails;

    // Percent chance of a sender gap before an item and of a receiver stall
    // in any cycle; each phase sets its own pair.
    int gap_pct;
    int stall_pct;
    int bytes_sent;

    always #5 aclk = ~aclk;

    xor_checked_packet_deframer #(
        .MAX_DATA (MAX_DATA)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_length  (m_frame_length),
        .m_frame_type    (m_frame_type),
        .m_frame_source  (m_frame_source),
        .m_frame_dest    (m_frame_dest),
        .m_receiving     (m_receiving)
    );

    xcpd_frame_checker #(
        .MAX_DATA (MAX_DATA)
    ) u_frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_length  (m_frame_length),
        .m_frame_type    (m_frame_type),
        .m_frame_source  (m_frame_source),
        .m_frame_dest    (m_frame_dest),
        .m_receiving     (m_receiving),
        .mismatch_count  (mismatch_count),
        .results_waiting (results_waiting),
        .frames_good     (frames_good),
        .frames_bad      (frames_bad),
        .header_fails    (header_fails)
    );

    // The receiver redraws its ready every cycle, so stalls land on any
    // phase of the output handshake, including while m_valid is held.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Presents one byte and holds it until the deframer takes it. A gap,
    // when drawn, drops valid first, extended while redraws hit; otherwise valid
    // stays high straight into the next item with only the payload changing.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Sends one frame. A nonzero hdr_flip corrupts the header check byte,
    // which ends the frame right there. A nonzero pay_flip corrupts the
    // trailing XOR byte. Lengths above MAX_DATA are cut to MAX_DATA+1
    // payload bytes, just as the deframer counts them.
    task automatic send_frame(input logic [7:0] len, typ, src, dst, hdr_flip, pay_flip);
        int         n;
        logic [7:0] acc;
        logic [7:0] b;
        send_byte(len);
        send_byte(typ);
        send_byte(src);
        send_byte(dst);
        send_byte(len ^ typ ^ src ^ dst ^ 8'hFF ^ hdr_flip);
        if (hdr_flip == 8'h00) begin
            n   = (len > MAX_DATA) ? int'(MAX_DATA) + 1 : int'(len) + 1;
            acc = 8'h00;
            for (int i = 0; i < n - 1; i++) begin
                b    = 8'($urandom);
                acc ^= b;
                send_byte(b);
            end
            send_byte(acc ^ pay_flip);
        end
    endtask

    // Lets every expected result drain before anything is reconfigured.
    // Every byte yields a result, so an empty expectation store means the
    // deframer holds nothing in flight.
    task automatic wait_drained();
        if (s_valid)
            s_valid <= 1'b0;
        @(posedge aclk);
        while (results_waiting != 0) @(posedge aclk);
    endtask

    task automatic write_bypass(input logic value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed frames with random contents, so the payload and
    // trailer checks are reached often. The rest are broken headers and
    // loose random bytes. Lengths are mostly short; a few run to the cap
    // and beyond it, including the largest length byte.
    task automatic random_traffic(input int target);
        int         r;
        logic [7:0] len;
        logic [7:0] typ;
        logic [7:0] hdr_flip;
        logic [7:0] pay_flip;
        while (bytes_sent < target) begin
            r = int'($urandom_range(99));
            if (r < 5) begin
                repeat (5) send_byte(8'($urandom));
            end else begin
                r = int'($urandom_range(99));
                if (r < 55)
                    len = 8'($urandom_range(6));
                else if (r < 80)
                    len = 8'($urandom_range(MAX_DATA, 7));
                else if (r < 90)
                    len = 8'($urandom_range(255, MAX_DATA + 1));
                else if (r < 95)
                    len = 8'(MAX_DATA);
                else
                    len = 8'hFF;
                typ      = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
                hdr_flip = ($urandom_range(99) < 15) ? 8'($urandom_range(255, 1)) : 8'h00;
                pay_flip = ($urandom_range(99) < 40) ? 8'($urandom_range(255, 1)) : 8'h00;
                send_frame(len, typ, 8'($urandom), 8'($urandom), hdr_flip, pay_flip);
            end
        end
    endtask

    initial begin
        int directed_bytes;
        aresetn    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= 1'b0;
        s_valid    <= 1'b0;
        s_rx_byte  <= 8'h00;
        gap_pct    = 0;
        stall_pct  = 0;
        bytes_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames with the bypass at its reset value of one.
        // All-zero header: the check byte should have been 0xFF.
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00);
        // Type zero with a wrong trailer still passes through the bypass.
        send_frame(8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h3C);
        // Nonzero type with a wrong trailer fails the payload check.
        send_frame(8'h01, 8'h80, 8'h01, 8'hFE, 8'h00, 8'h01);
        // All-ones type with a correct trailer.
        send_frame(8'h02, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'h00);
        directed_bytes = bytes_sent;

        // Four pressure phases; the bypass flips at each, so each setting sees
        // two of the four pressure patterns in turn.
        for (int phase = 0; phase < 4; phase++) begin
            write_bypass(phase[0]);
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 55; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 55; end
                default: begin gap_pct = 28; stall_pct = 28; end
            endcase
            random_traffic(directed_bytes + (phase + 1) * PHASE_BYTES);
        end

        wait_drained();
        repeat (4) @(posedge aclk);

        $display("Sent %0d bytes (%0d directed) over four handshake phases, bypass on and off.",
                 bytes_sent, directed_bytes);
        $display("Frames seen: %0d good, %0d bad, %0d rejected headers; %0d mismatches.",
                 frames_good, frames_bad, header_fails, mismatch_count);
        if (mismatch_count == 0 && results_waiting == 0) begin
            $display("** xor_checked_packet_deframer: PASSED **");
        end else begin
            $display("** xor_checked_packet_deframer: FAILED **");
        end
        $finish;
    end

    // A watchdog set far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("** xor_checked_packet_deframer: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/xcpd_pkg.sv
rtl/xcpd_in_stage.sv
rtl/xcpd_core.sv
rtl/xcpd_out_stage.sv
rtl/xor_checked_packet_deframer.sv
dv/xcpd_frame_checker.sv
dv/tb_xor_checked_packet_deframer.sv
